/* hw/rtl/urxf_pkg.sv */
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared constants, codes and control types of the receive FIFO with
// escape detection.
// ----------------------------------------------------------------------------
package urxf_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [7:0] ESCAPE_BYTE = 8'd17;

    // input item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;

    // configuration register indexes
    localparam logic REG_TIMER_MASK = 1'b0;
    localparam logic REG_IRQ_MASK   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_OUT   = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic tick;       // process a tick item and load its result
        logic empty;      // load a result without data
        logic start_run;  // latch run length of a read
        logic pop;        // issue a store read and advance the read side
        logic load_pop;   // load a result from the store read data
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic run_zero;   // current read item delivers no byte
        logic more;       // bytes of the current run still to pop
    } t_stat;

endpackage

/* hw/rtl/urxf_ram.sv */
// ----------------------------------------------------------------------------
// urxf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/urxf_ctrl.sv */
// ----------------------------------------------------------------------------
// urxf_ctrl
// Sequencer: accepts one item, steps the store reads of a run and holds
// each result until it is taken.
// ----------------------------------------------------------------------------
module urxf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  urxf_pkg::t_stat i_stat,
    output urxf_pkg::t_cmd  o_cmd
);
    import urxf_pkg::*;

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == KIND_TICK) begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_OUT;
                    end else if (i_stat.run_zero) begin
                        o_cmd.empty = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        o_cmd.start_run = 1'b1;
                        o_cmd.pop       = 1'b1;
                        n_state         = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.load_pop = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_stat.more) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // a fetched byte always turns into a shown result next cycle
    a_fetch_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_OUT))
        else $error("fetch not followed by result");

    // a pop comes only from acceptance or after a taken result
    a_pop_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> (w_accept || (o_out_valid && i_out_ready)))
        else $error("pop without handshake");

    // a result that is shown but not taken stays shown
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn");

endmodule

/* hw/rtl/urxf_dpath.sv */
// ----------------------------------------------------------------------------
// urxf_dpath
// Datapath: store, pointers, fill count, escape memory, run counters and
// the result register.
// ----------------------------------------------------------------------------
module urxf_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  urxf_pkg::t_cmd  i_cmd,
    output urxf_pkg::t_stat o_stat,
    input  logic [1:0]    i_kind,
    input  logic          i_rx_present,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_request_count,
    input  logic          i_timer_mask,
    input  logic          i_irq_mask,
    output logic [7:0]    o_data_byte,
    output logic          o_data_valid,
    output logic          o_last,
    output logic [6:0]    o_returned_count,
    output logic          o_irq_event,
    output logic          o_nmi_event,
    output logic          o_byte_dropped,
    output logic [6:0]    o_fill_level
);
    import urxf_pkg::*;

    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_prev;
    logic [CNT_W-1:0] r_total, r_remaining;

    logic [7:0]       r_data_byte;
    logic             r_data_valid, r_last, r_irq, r_nmi, r_drop;
    logic [6:0]       r_returned, r_fill;

    logic [7:0]       w_rdata;
    logic             w_escape, w_push, w_full;
    logic [CNT_W-1:0] w_run_len;
    logic [7:0]       w_count8;

    // tick decode
    assign w_escape = i_rx_present && (r_prev == ESCAPE_BYTE) && (i_rx_byte == ESCAPE_BYTE);
    assign w_full   = (r_count == CNT_W'(BUF_DEPTH));
    assign w_push   = i_cmd.tick && i_rx_present && !w_escape && !w_full;

    // run length of a read item
    assign w_count8 = 8'(r_count);
    always_comb begin
        case (i_kind)
            KIND_SINGLE: w_run_len = (r_count != '0) ? CNT_W'(1) : '0;
            KIND_STRING: w_run_len = (i_request_count < w_count8) ?
                                     CNT_W'(i_request_count) : r_count;
            default:     w_run_len = '0;
        endcase
    end

    assign o_stat.run_zero = (w_run_len == '0);
    assign o_stat.more     = (r_remaining != '0);

    urxf_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH), .ADDR_W(PTR_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wp),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.pop),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

    // pointers, fill count and escape memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cmd.tick && i_rx_present) begin
                r_prev <= w_escape ? 8'd0 : i_rx_byte;
            end
            if (w_push) begin
                r_wp    <= (r_wp == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.pop) begin
                r_rp    <= (r_rp == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_rp + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_remaining <= '0;
        end else if (i_cmd.start_run) begin
            r_total     <= w_run_len;
            r_remaining <= w_run_len - 1'b1;
        end else if (i_cmd.pop) begin
            r_remaining <= r_remaining - 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_data_byte  <= 8'd0;
            r_data_valid <= 1'b0;
            r_last       <= 1'b1;
            r_returned   <= 7'd0;
            r_irq        <= !w_escape && !i_timer_mask && !i_irq_mask;
            r_nmi        <= w_escape;
            r_drop       <= i_rx_present && !w_escape && w_full;
            r_fill       <= 7'(r_count) + 7'(w_push);
        end else if (i_cmd.empty) begin
            r_data_byte  <= 8'd0;
            r_data_valid <= 1'b0;
            r_last       <= 1'b1;
            r_returned   <= 7'd0;
            r_irq        <= 1'b0;
            r_nmi        <= 1'b0;
            r_drop       <= 1'b0;
            r_fill       <= 7'(r_count);
        end else if (i_cmd.load_pop) begin
            r_data_byte  <= w_rdata;
            r_data_valid <= 1'b1;
            r_last       <= (r_remaining == '0);
            r_returned   <= 7'(r_total);
            r_irq        <= 1'b0;
            r_nmi        <= 1'b0;
            r_drop       <= 1'b0;
            r_fill       <= 7'(r_count);
        end
    end

    assign o_data_byte      = r_data_byte;
    assign o_data_valid     = r_data_valid;
    assign o_last           = r_last;
    assign o_returned_count = r_returned;
    assign o_irq_event      = r_irq;
    assign o_nmi_event      = r_nmi;
    assign o_byte_dropped   = r_drop;
    assign o_fill_level     = r_fill;

    // fill count stays within the store
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUF_DEPTH))
        else $error("fill count beyond depth");

    // never pop an empty store
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from empty store");

    // push and pop never meet in one cycle
    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && i_cmd.pop))
        else $error("push and pop together");

endmodule

/* hw/rtl/uart_rx_fifo_with_break_detect.sv */
// ----------------------------------------------------------------------------
// uart_rx_fifo_with_break_detect
// Receive FIFO with double-escape NMI detection, periodic IRQ event and
// non-blocking single and string reads.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_ready   i_kind, i_rx_present,
//                                                 i_rx_byte, i_request_count
//   output   out        o_out_valid / i_out_ready o_data_byte .. o_fill_level
//   config   in         APB psel/penable/pwrite   paddr[2:0], pwdata[31:0]
//
// A tick or an empty read is accepted and then loaded into the result register.
// In a string read each byte goes through the registered read port of the
// store and then the result register.
// One item is in work at a time; a stalled result holds the sequencer.
// Synchronous active-low reset clears pointers, fill count and escape memory;
// the store needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_rx_fifo_with_break_detect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_rx_present,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_request_count,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_last,
    output logic [6:0]  o_returned_count,
    output logic        o_irq_event,
    output logic        o_nmi_event,
    output logic        o_byte_dropped,
    output logic [6:0]  o_fill_level,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import urxf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  r_timer_mask, r_irq_mask;
    logic  w_reg_sel;

    // configuration registers, word index in paddr[2]
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_mask <= 1'b1;
            r_irq_mask   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (w_reg_sel == REG_TIMER_MASK) begin
                r_timer_mask <= pwdata[0];
            end else begin
                r_irq_mask <= pwdata[0];
            end
        end
    end

    assign prdata = {31'd0, (w_reg_sel == REG_IRQ_MASK) ? r_irq_mask : r_timer_mask};

    urxf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    urxf_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_kind           (i_kind),
        .i_rx_present     (i_rx_present),
        .i_rx_byte        (i_rx_byte),
        .i_request_count  (i_request_count),
        .i_timer_mask     (r_timer_mask),
        .i_irq_mask       (r_irq_mask),
        .o_data_byte      (o_data_byte),
        .o_data_valid     (o_data_valid),
        .o_last           (o_last),
        .o_returned_count (o_returned_count),
        .o_irq_event      (o_irq_event),
        .o_nmi_event      (o_nmi_event),
        .o_byte_dropped   (o_byte_dropped),
        .o_fill_level     (o_fill_level)
    );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the receive FIFO with double-escape NMI detection.
// A queue of items feeds a valid/ready driver. The monitor predicts every
// accepted item with a local copy of the FIFO, the escape memory and the mask
// registers. It checks each result, field by field, in order. Mask registers
// are written over APB between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import urxf_pkg::*;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         LONG_HOLD      = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic       present;
        logic [7:0] rx;
        logic [7:0] req;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
        logic [6:0] returned_count;
        logic       irq_event;
        logic       nmi_event;
        logic       byte_dropped;
        logic [6:0] fill_level;
    } t_fifo_result;

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = '0;
    logic        i_rx_present = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic [7:0]  i_request_count = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_data_valid;
    logic        o_last;
    logic [6:0]  o_returned_count;
    logic        o_irq_event;
    logic        o_nmi_event;
    logic        o_byte_dropped;
    logic [6:0]  o_fill_level;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // bench state
    t_rx_item     item_queue[$];
    t_fifo_result rx_results_due[$];
    logic         in_taken = 1'b0;
    logic         idle_on = 1'b1;
    logic         hold_request = 1'b0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;
    int           items_taken = 0;
    int           results_checked = 0;
    int           nmi_seen = 0;
    int           drops_seen = 0;
    int           irq_seen = 0;
    int unsigned  deepest_fill = 0;

    // predicted block state
    logic [7:0]   store_q [BUF_DEPTH];
    int unsigned  wr_ptr_q = 0;
    int unsigned  rd_ptr_q = 0;
    int unsigned  fill_q = 0;
    logic [7:0]   prev_byte_q = '0;
    logic         timer_mask_q = 1'b1;
    logic         irq_mask_q = 1'b0;

    uart_rx_fifo_with_break_detect u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_rx_present     (i_rx_present),
        .i_rx_byte        (i_rx_byte),
        .i_request_count  (i_request_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_data_byte      (o_data_byte),
        .o_data_valid     (o_data_valid),
        .o_last           (o_last),
        .o_returned_count (o_returned_count),
        .o_irq_event      (o_irq_event),
        .o_nmi_event      (o_nmi_event),
        .o_byte_dropped   (o_byte_dropped),
        .o_fill_level     (o_fill_level),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Generate the clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compute the results of one accepted item and advance the local FIFO
    function automatic void predict_fifo_step(t_rx_item it);
        t_fifo_result r;
        int unsigned  n;
        r = '0;
        r.last = 1'b1;
        case (it.kind)
            KIND_TICK: begin
                if (it.present && prev_byte_q == ESCAPE_BYTE && it.rx == ESCAPE_BYTE) begin
                    // second escape in a row: clear memory, no store, no IRQ
                    prev_byte_q = '0;
                    r.nmi_event = 1'b1;
                    nmi_seen++;
                end else begin
                    if (it.present) begin
                        prev_byte_q = it.rx;
                        if (fill_q < BUF_DEPTH) begin
                            store_q[wr_ptr_q] = it.rx;
                            wr_ptr_q = (wr_ptr_q + 1) % BUF_DEPTH;
                            fill_q++;
                        end else begin
                            r.byte_dropped = 1'b1;
                            drops_seen++;
                        end
                    end
                    r.irq_event = !timer_mask_q && !irq_mask_q;
                    if (r.irq_event) irq_seen++;
                end
                r.fill_level = 7'(fill_q);
                if (fill_q > deepest_fill) deepest_fill = fill_q;
                rx_results_due.push_back(r);
            end
            KIND_SINGLE, KIND_STRING: begin
                n = (it.kind == KIND_SINGLE) ? 1 : it.req;
                if (n > fill_q) n = fill_q;
                if (n == 0) begin
                    r.fill_level = 7'(fill_q);
                    rx_results_due.push_back(r);
                end else begin
                    // pop a run of n bytes, one result each
                    for (int i = 0; i < n; i++) begin
                        r.data_byte = store_q[rd_ptr_q];
                        rd_ptr_q = (rd_ptr_q + 1) % BUF_DEPTH;
                        fill_q--;
                        r.data_valid = 1'b1;
                        r.last = (i == n - 1);
                        r.returned_count = 7'(n);
                        r.fill_level = 7'(fill_q);
                        rx_results_due.push_back(r);
                    end
                end
            end
            default: begin
                r.fill_level = 7'(fill_q);
                rx_results_due.push_back(r);
            end
        endcase
    endfunction

    function automatic string describe(t_fifo_result r);
        return $sformatf("data=%02h dv=%0b last=%0b cnt=%0d irq=%0b nmi=%0b drop=%0b fill=%0d",
                         r.data_byte, r.data_valid, r.last, r.returned_count,
                         r.irq_event, r.nmi_event, r.byte_dropped, r.fill_level);
    endfunction

    // Driver: offer the next pending item, idle at random
    always @(negedge i_clk) begin
        t_rx_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (item_queue.size() != 0 && !(idle_on && $urandom_range(99) < 17)) begin
                it = item_queue.pop_front();
                i_kind          <= it.kind;
                i_rx_present    <= it.present;
                i_rx_byte       <= it.rx;
                i_request_count <= it.req;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_on && $urandom_range(99) < 17);
        end
    end

    // Monitor: predict accepted items, check accepted results
    always @(posedge i_clk) begin
        t_rx_item     taken;
        t_fifo_result got;
        t_fifo_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                taken.kind    = i_kind;
                taken.present = i_rx_present;
                taken.rx      = i_rx_byte;
                taken.req     = i_request_count;
                predict_fifo_step(taken);
                items_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                got.data_byte      = o_data_byte;
                got.data_valid     = o_data_valid;
                got.last           = o_last;
                got.returned_count = o_returned_count;
                got.irq_event      = o_irq_event;
                got.nmi_event      = o_nmi_event;
                got.byte_dropped   = o_byte_dropped;
                got.fill_level     = o_fill_level;
                results_checked++;
                if (rx_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: %s", describe(got));
                end else begin
                    want = rx_results_due.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("mismatch at result %0d", results_checked);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles, %0d results outstanding",
                     quiet_cycles, rx_results_due.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_item(logic [1:0] kind, logic present, logic [7:0] rx,
                                       logic [7:0] req);
        t_rx_item it;
        it.kind    = kind;
        it.present = present;
        it.rx      = rx;
        it.req     = req;
        item_queue.push_back(it);
    endfunction

    // Mix of ticks, escape pairs, single and string reads, and unused kinds
    task automatic queue_random_items(int count);
        int unsigned sel;
        logic [7:0]  req;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            req = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
            if (sel < 8) begin
                queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'($urandom));
                queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'($urandom));
            end else if (sel < 55) begin
                queue_item(KIND_TICK, 1'b1, 8'($urandom), 8'($urandom));
            end else if (sel < 62) begin
                queue_item(KIND_TICK, 1'b0, 8'($urandom), 8'($urandom));
            end else if (sel < 77) begin
                queue_item(KIND_SINGLE, 1'($urandom), 8'($urandom), 8'($urandom));
            end else if (sel < 94) begin
                queue_item(KIND_STRING, 1'($urandom), 8'($urandom), req);
            end else if (sel < 97) begin
                queue_item(KIND_UNUSED, 1'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'($urandom));
            end
        end
    endtask

    // Overfill the FIFO, then drain it with the longest string read
    task automatic queue_fill_burst();
        logic [7:0] b;
        for (int k = 0; k < BUF_DEPTH + 4; k++) begin
            b = 8'($urandom);
            if (b == ESCAPE_BYTE) b = ~b;
            queue_item(KIND_TICK, 1'b1, b, 8'($urandom));
        end
        queue_item(KIND_STRING, 1'b0, 8'h00, 8'hFF);
    endtask

    // Hold until every item is accepted and every result has come
    task automatic wait_drained();
        while (item_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (rx_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TIMER_MASK) timer_mask_q = value;
        else irq_mask_q = value;
    endtask

    // Stimulus: directed cases, then random phases and a fill burst under each mask setting
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty reads, unused kind, ticks at reset masks
        queue_item(KIND_SINGLE, 1'b0, 8'h00, 8'h00);
        queue_item(KIND_STRING, 1'b0, 8'h00, 8'h00);
        queue_item(KIND_STRING, 1'b1, 8'hFF, 8'hFF);
        queue_item(KIND_UNUSED, 1'b1, 8'hFF, 8'hFF);
        queue_item(KIND_TICK, 1'b0, 8'hFF, 8'hFF);
        queue_item(KIND_TICK, 1'b1, 8'h00, 8'h00);
        queue_item(KIND_TICK, 1'b1, 8'hFF, 8'h00);
        // escape pair raises NMI; a third escape is stored again
        queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'h00);
        queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'h00);
        queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'h00);
        queue_item(KIND_TICK, 1'b1, 8'hAA, 8'h00);
        queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'h00);
        // pops: single, zero-length string, short string, oversize string
        queue_item(KIND_SINGLE, 1'b0, 8'h00, 8'h00);
        queue_item(KIND_STRING, 1'b0, 8'h00, 8'h00);
        queue_item(KIND_STRING, 1'b0, 8'h00, 8'h01);
        queue_item(KIND_STRING, 1'b0, 8'h00, 8'hFF);
        queue_item(KIND_SINGLE, 1'b0, 8'h00, 8'h00);
        wait_drained();

        // interrupt enabled: ticks raise IRQ, except on an NMI
        write_reg(REG_TIMER_MASK, 1'b0);
        write_reg(REG_IRQ_MASK, 1'b0);
        queue_item(KIND_TICK, 1'b0, 8'h55, 8'h00);
        queue_item(KIND_TICK, 1'b1, 8'h5A, 8'h00);
        queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'h00);
        queue_item(KIND_TICK, 1'b1, ESCAPE_BYTE, 8'h00);
        wait_drained();

        // long stretch without idling
        idle_on = 1'b0;
        queue_random_items(25);
        wait_drained();
        idle_on = 1'b1;

        // receiver holds off for a long stretch; the sender overfills the FIFO
        write_reg(REG_IRQ_MASK, 1'b1);
        hold_request = 1'b1;
        queue_fill_burst();
        wait_drained();

        write_reg(REG_TIMER_MASK, 1'b1);
        write_reg(REG_IRQ_MASK, 1'b0);
        queue_random_items(20);
        wait_drained();

        write_reg(REG_TIMER_MASK, 1'b0);
        queue_random_items(20);
        wait_drained();

        write_reg(REG_TIMER_MASK, 1'b1);
        write_reg(REG_IRQ_MASK, 1'b1);
        queue_random_items(10);
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("covered %0d items and %0d results under all four mask settings",
                 items_taken, results_checked);
        $display("NMI %0d, dropped %0d, IRQ %0d, deepest fill %0d, mismatches %0d",
                 nmi_seen, drops_seen, irq_seen, deepest_fill, mismatch_count);
        if (mismatch_count == 0 && rx_results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
